// ===== design/drrip_pkg.sv =====
package drrip_pkg;

    localparam int SETS           = 64;
    localparam int WAYS           = 4;
    localparam int OFFSET_BITS    = 6;
    localparam int LEADER_SETS    = 16;
    localparam int PSEL_TOP       = 1023;
    localparam int BIMODAL_PERIOD = 32;

    localparam int ADDR_BITS = 32;
    localparam int SET_BITS  = $clog2(SETS + 1) - 1;
    localparam int SET_COUNT = 2 ** SET_BITS;
    localparam int TAG_BITS  = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int RRPV_BITS = 2;
    localparam int PSEL_BITS = $clog2(PSEL_TOP + 1);
    localparam int PSEL_MID  = (PSEL_TOP + 1) / 2;
    localparam int BIM_BITS  = $clog2(BIMODAL_PERIOD);

    localparam logic [RRPV_BITS-1:0] RRPV_TOP  = 2'd3;
    localparam logic [RRPV_BITS-1:0] RRPV_LONG = 2'd2;
    localparam logic [RRPV_BITS-1:0] RRPV_NEAR = 2'd0;

    typedef logic [TAG_BITS-1:0]  tag_t;
    typedef logic [RRPV_BITS-1:0] rrpv_t;
    typedef logic [SET_BITS-1:0]  set_t;
    typedef logic [WAY_BITS-1:0]  way_t;

    typedef struct packed {
        tag_t  [WAYS-1:0] tags;
        rrpv_t [WAYS-1:0] rrpv;
    } row_t;

    localparam int ROW_BITS = $bits(row_t);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

// ===== design/drrip_req_if.sv =====
interface drrip_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] address;

    modport source (output valid, output address, input ready);
    modport sink (input valid, input address, output ready);
endinterface

// ===== design/drrip_rsp_if.sv =====
interface drrip_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] way;

    modport source (output valid, output hit, output way, input ready);
    modport sink (input valid, input hit, input way, output ready);
endinterface

// ===== design/drrip_set_assoc_cache.sv =====
// A request's set row is read on accept; the lookup state compares, ages and writes it back.
// Requests do not overlap: a new one is taken only after the previous row is written back.
// A new request is taken while the previous response still waits, if it is taken that cycle.
// Reset (async, active low): valid bits clear, policy counter to midpoint, bimodal counter to 0.
// Tag and RRPV rows need no clearing pass; invalid ways are never matched or aged.
module drrip_set_assoc_cache (
    input  logic               clk,
    input  logic               rst_n,
    drrip_req_if.sink          req,
    drrip_rsp_if.source        rsp
);

    drrip_pkg::state_t state_reg, state_next;

    drrip_pkg::set_t set_reg, set_next;
    drrip_pkg::tag_t tag_reg, tag_next;

    logic [drrip_pkg::SET_COUNT-1:0][drrip_pkg::WAYS-1:0] valid_reg, valid_next;
    logic [drrip_pkg::PSEL_BITS-1:0] psel_reg, psel_next;
    logic [drrip_pkg::BIM_BITS-1:0]  bim_reg, bim_next;

    logic       rsp_valid_reg, rsp_valid_next;
    logic       rsp_hit_reg, rsp_hit_next;
    logic [1:0] rsp_way_reg, rsp_way_next;

    logic                          accept;
    logic                          ram_we;
    logic [drrip_pkg::ROW_BITS-1:0] ram_rdata;
    drrip_pkg::row_t               row_rd, row_wr;
    drrip_pkg::set_t               req_set;

    logic [drrip_pkg::WAYS-1:0] way_valid;
    logic                       hit_any, inv_any, all_valid, srrip;
    drrip_pkg::way_t            hit_way, inv_way, full_way, victim;
    drrip_pkg::rrpv_t           rrpv_peak, age, ins_rrpv;
    logic [drrip_pkg::BIM_BITS:0] bim_sum;
    logic                       full_found;

    assign req_set   = req.address[drrip_pkg::OFFSET_BITS +: drrip_pkg::SET_BITS];
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == drrip_pkg::ST_IDLE) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.hit   = rsp_hit_reg;
    assign rsp.way   = rsp_way_reg;

    assign row_rd = drrip_pkg::row_t'(ram_rdata);

    drrip_ram #(
        .WIDTH (drrip_pkg::ROW_BITS),
        .DEPTH (drrip_pkg::SET_COUNT)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (accept),
        .raddr (req_set),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drrip_pkg::ST_IDLE;
            valid_reg     <= '0;
            psel_reg      <= drrip_pkg::PSEL_BITS'(drrip_pkg::PSEL_MID);
            bim_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            psel_reg      <= psel_next;
            bim_reg       <= bim_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg     <= set_next;
        tag_reg     <= tag_next;
        rsp_hit_reg <= rsp_hit_next;
        rsp_way_reg <= rsp_way_next;
    end

    always_comb
    begin
        way_valid  = valid_reg[set_reg];
        hit_any    = 1'b0;
        hit_way    = '0;
        inv_any    = 1'b0;
        inv_way    = '0;
        rrpv_peak  = '0;
        full_found = 1'b0;
        full_way   = '0;

        for (int w = 0; w < drrip_pkg::WAYS; w++)
        begin
            if (!hit_any && way_valid[w] && row_rd.tags[w] == tag_reg)
            begin
                hit_any = 1'b1;
                hit_way = drrip_pkg::WAY_BITS'(w);
            end
            if (!inv_any && !way_valid[w])
            begin
                inv_any = 1'b1;
                inv_way = drrip_pkg::WAY_BITS'(w);
            end
            if (row_rd.rrpv[w] > rrpv_peak)
            begin
                rrpv_peak = row_rd.rrpv[w];
            end
        end
        all_valid = !inv_any;
        age       = drrip_pkg::RRPV_TOP - rrpv_peak;

        for (int w = 0; w < drrip_pkg::WAYS; w++)
        begin
            if (!full_found && row_rd.rrpv[w] == rrpv_peak)
            begin
                full_found = 1'b1;
                full_way   = drrip_pkg::WAY_BITS'(w);
            end
        end
        victim = all_valid ? full_way : inv_way;

        psel_next = psel_reg;
        if (state_reg == drrip_pkg::ST_LOOKUP && !hit_any && all_valid)
        begin
            if (32'(set_reg) < drrip_pkg::LEADER_SETS)
            begin
                if (psel_reg != '0)
                begin
                    psel_next = psel_reg - drrip_pkg::PSEL_BITS'(1);
                end
            end
            else if (32'(set_reg) < 2 * drrip_pkg::LEADER_SETS)
            begin
                if (psel_reg != drrip_pkg::PSEL_BITS'(drrip_pkg::PSEL_TOP))
                begin
                    psel_next = psel_reg + drrip_pkg::PSEL_BITS'(1);
                end
            end
        end

        if (32'(set_reg) < drrip_pkg::LEADER_SETS)
        begin
            srrip = 1'b1;
        end
        else if (32'(set_reg) < 2 * drrip_pkg::LEADER_SETS)
        begin
            srrip = 1'b0;
        end
        else
        begin
            srrip = psel_next >= drrip_pkg::PSEL_BITS'(drrip_pkg::PSEL_MID);
        end

        bim_next = bim_reg;
        bim_sum  = {1'b0, bim_reg} + (drrip_pkg::BIM_BITS + 1)'(1);
        ins_rrpv = drrip_pkg::RRPV_LONG;
        if (!srrip)
        begin
            if (bim_sum >= (drrip_pkg::BIM_BITS + 1)'(drrip_pkg::BIMODAL_PERIOD))
            begin
                ins_rrpv = drrip_pkg::RRPV_LONG;
                if (state_reg == drrip_pkg::ST_LOOKUP && !hit_any)
                begin
                    bim_next = '0;
                end
            end
            else
            begin
                ins_rrpv = drrip_pkg::RRPV_TOP;
                if (state_reg == drrip_pkg::ST_LOOKUP && !hit_any)
                begin
                    bim_next = bim_sum[drrip_pkg::BIM_BITS-1:0];
                end
            end
        end

        row_wr = row_rd;
        if (hit_any)
        begin
            row_wr.rrpv[hit_way] = drrip_pkg::RRPV_NEAR;
        end
        else
        begin
            if (all_valid)
            begin
                for (int w = 0; w < drrip_pkg::WAYS; w++)
                begin
                    row_wr.rrpv[w] = row_rd.rrpv[w] + age;
                end
            end
            row_wr.tags[victim] = tag_reg;
            row_wr.rrpv[victim] = ins_rrpv;
        end

        valid_next = valid_reg;
        if (state_reg == drrip_pkg::ST_LOOKUP && !hit_any)
        begin
            valid_next[set_reg][victim] = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        ram_we         = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        rsp_hit_next   = rsp_hit_reg;
        rsp_way_next   = rsp_way_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            drrip_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    set_next   = req_set;
                    tag_next   = req.address[drrip_pkg::ADDR_BITS-1 -: drrip_pkg::TAG_BITS];
                    state_next = drrip_pkg::ST_LOOKUP;
                end
            end
            drrip_pkg::ST_LOOKUP:
            begin
                ram_we         = 1'b1;
                rsp_valid_next = 1'b1;
                rsp_hit_next   = hit_any;
                rsp_way_next   = hit_any ? 2'(hit_way) : 2'(victim);
                state_next     = drrip_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = drrip_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/drrip_ram.sv =====
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int SAT_EXTRA    = 40;

    localparam logic MISS = 1'b0;
    localparam logic HIT  = 1'b1;

    typedef struct packed {
        logic       hit;
        logic [1:0] way;
    } lookup_t;

    typedef struct packed {
        logic [31:0] address;
        logic        exact;
        logic        hit;
        logic [1:0]  way;
    } access_row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam access_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        {32'h0000_0000, 1'b1, MISS, 2'd0},
        {32'h0000_003F, 1'b1, HIT,  2'd0},
        {32'hFFFF_FFFF, 1'b1, MISS, 2'd0},
        {32'hFFFF_FFC0, 1'b1, HIT,  2'd0},
        {32'h0000_1000, 1'b1, MISS, 2'd1},
        {32'h0000_2000, 1'b1, MISS, 2'd2},
        {32'h0000_3000, 1'b1, MISS, 2'd3},
        {32'h0000_0000, 1'b1, HIT,  2'd0},
        {32'h0000_4000, 1'b1, MISS, 2'd1},
        {32'h0000_1000, 1'b1, MISS, 2'd2},
        {32'h0000_0400, 1'b1, MISS, 2'd0},
        {32'h0000_1400, 1'b1, MISS, 2'd1},
        {32'h0000_2400, 1'b1, MISS, 2'd2},
        {32'h0000_3400, 1'b1, MISS, 2'd3},
        {32'h0000_4400, 1'b1, MISS, 2'd0},
        {32'h0000_0400, 1'b1, MISS, 2'd0},
        {32'h0000_0A00, 1'b1, MISS, 2'd0},
        {32'h0000_0A2A, 1'b1, HIT,  2'd0},
        {32'hFFFF_F000, 1'b0, MISS, 2'd0},
        {32'h8000_0FC0, 1'b0, MISS, 2'd0},
        {32'h0000_0FC0, 1'b0, MISS, 2'd0},
        {32'h5555_5A95, 1'b0, MISS, 2'd0},
        {32'hAAAA_A56A, 1'b0, MISS, 2'd0},
        {32'h0000_4000, 1'b0, MISS, 2'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    drrip_req_if req_if ();
    drrip_rsp_if rsp_if ();

    drrip_set_assoc_cache i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    drrip_pkg::tag_t  tag_mem   [drrip_pkg::SET_COUNT][drrip_pkg::WAYS];
    logic             valid_mem [drrip_pkg::SET_COUNT][drrip_pkg::WAYS];
    drrip_pkg::rrpv_t rrpv_mem  [drrip_pkg::SET_COUNT][drrip_pkg::WAYS];
    int    psel_count;
    int    bimodal_count;

    lookup_t expected_lookups [$];

    int mismatch_count = 0;
    int request_count  = 0;
    int response_count = 0;
    int hit_count      = 0;
    int evict_count    = 0;
    int cycle_count    = 0;
    bit psel_top_seen   = 1'b0;
    bit quiet           = 1'b0;
    bit long_hold_request = 1'b0;
    bit long_hold_done    = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic lookup_t cache_lookup(input logic [31:0] address);
        drrip_pkg::set_t set_idx;
        drrip_pkg::tag_t tag;
        lookup_t         outcome;
        int              victim;
        bit              srrip;
        set_idx = address[drrip_pkg::OFFSET_BITS +: drrip_pkg::SET_BITS];
        tag     = address[drrip_pkg::ADDR_BITS-1 -: drrip_pkg::TAG_BITS];
        victim  = -1;
        for (int w = 0; w < drrip_pkg::WAYS; w++)
            if (victim < 0 && valid_mem[set_idx][w] && tag_mem[set_idx][w] == tag)
                victim = w;
        if (victim >= 0)
        begin
            rrpv_mem[set_idx][victim] = drrip_pkg::RRPV_NEAR;
            hit_count++;
            outcome.hit = HIT;
            outcome.way = victim[1:0];
            return outcome;
        end
        for (int w = 0; w < drrip_pkg::WAYS; w++)
            if (victim < 0 && !valid_mem[set_idx][w])
                victim = w;
        if (victim < 0)
        begin
            evict_count++;
            if (set_idx < drrip_pkg::LEADER_SETS)
            begin
                if (psel_count > 0)
                    psel_count--;
            end
            else if (set_idx < 2 * drrip_pkg::LEADER_SETS)
            begin
                if (psel_count < drrip_pkg::PSEL_TOP)
                    psel_count++;
            end
            if (psel_count == drrip_pkg::PSEL_TOP)
                psel_top_seen = 1'b1;
            for (int round = 0; round <= int'(drrip_pkg::RRPV_TOP); round++)
            begin
                for (int w = 0; w < drrip_pkg::WAYS; w++)
                    if (victim < 0 && rrpv_mem[set_idx][w] == drrip_pkg::RRPV_TOP)
                        victim = w;
                if (victim < 0)
                    for (int w = 0; w < drrip_pkg::WAYS; w++)
                        if (rrpv_mem[set_idx][w] < drrip_pkg::RRPV_TOP)
                            rrpv_mem[set_idx][w] = rrpv_mem[set_idx][w]
                                                   + drrip_pkg::rrpv_t'(1);
            end
            if (victim < 0)
                victim = 0;
        end
        tag_mem[set_idx][victim]   = tag;
        valid_mem[set_idx][victim] = 1'b1;
        if (set_idx < drrip_pkg::LEADER_SETS)
            srrip = 1'b1;
        else if (set_idx < 2 * drrip_pkg::LEADER_SETS)
            srrip = 1'b0;
        else
            srrip = (psel_count >= drrip_pkg::PSEL_MID);
        if (srrip)
            rrpv_mem[set_idx][victim] = drrip_pkg::RRPV_LONG;
        else
        begin
            bimodal_count++;
            if (bimodal_count >= drrip_pkg::BIMODAL_PERIOD)
            begin
                bimodal_count = 0;
                rrpv_mem[set_idx][victim] = drrip_pkg::RRPV_LONG;
            end
            else
                rrpv_mem[set_idx][victim] = drrip_pkg::RRPV_TOP;
        end
        outcome.hit = MISS;
        outcome.way = victim[1:0];
        return outcome;
    endfunction

    function automatic logic [31:0] random_address(input int set_lo, input int set_hi,
                                                   input int tag_pool);
        drrip_pkg::tag_t                   tag;
        drrip_pkg::set_t                   set_idx;
        logic [drrip_pkg::OFFSET_BITS-1:0] offset;
        set_idx = drrip_pkg::set_t'($urandom_range(set_hi, set_lo));
        if (tag_pool == 0 || $urandom_range(0, 7) == 0)
            tag = drrip_pkg::tag_t'($urandom());
        else
            tag = drrip_pkg::tag_t'($urandom_range(tag_pool - 1, 0));
        offset = drrip_pkg::OFFSET_BITS'($urandom());
        return {tag, set_idx, offset};
    endfunction

    task automatic check_lookup(input logic hit, input logic [1:0] way);
        lookup_t want;
        if (expected_lookups.size() == 0)
        begin
            $display("%0t: response with none outstanding, expected nothing, actual hit %0d way %0d",
                     $time, hit, way);
            mismatch_count++;
            return;
        end
        want = expected_lookups.pop_front();
        response_count++;
        if (hit !== want.hit)
        begin
            $display("%0t: hit mismatch, expected %0d, actual %0d", $time, want.hit, hit);
            mismatch_count++;
        end
        if (way !== want.way)
        begin
            $display("%0t: way mismatch, expected %0d, actual %0d", $time, want.way, way);
            mismatch_count++;
        end
    endtask

    task automatic send_request(input logic [31:0] address);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.address <= address;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        request_count++;
    endtask

    task automatic issue_access(input logic [31:0] address);
        send_request(address);
        expected_lookups.push_back(cache_lookup(address));
    endtask

    task automatic drain_lookups();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_lookups.size() != 0);
    endtask

    // response side: random hold-offs, one long one on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
                check_lookup(rsp_if.hit, rsp_if.way);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                long_hold_done    = 1'b1;
                hold_left         = LONG_HOLD;
            end
            else if (hold_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                hold_left = $urandom_range(1, 8);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int      extra;
        lookup_t predicted;
        req_if.valid   <= 1'b0;
        req_if.address <= '0;
        rst_n          <= 1'b0;
        for (int s = 0; s < drrip_pkg::SET_COUNT; s++)
            for (int w = 0; w < drrip_pkg::WAYS; w++)
            begin
                valid_mem[s][w] = 1'b0;
                rrpv_mem[s][w]  = drrip_pkg::RRPV_TOP;
                tag_mem[s][w]   = '0;
            end
        psel_count    = drrip_pkg::PSEL_MID;
        bimodal_count = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(DIRECTED[i].address);
            predicted = cache_lookup(DIRECTED[i].address);
            if (DIRECTED[i].exact)
                expected_lookups.push_back({DIRECTED[i].hit, DIRECTED[i].way});
            else
                expected_lookups.push_back(predicted);
        end
        drain_lookups();

        // mixed traffic over all sets, long response hold-off partway
        for (int i = 0; i < 400; i++)
        begin
            if (i == 150)
                long_hold_request = 1'b1;
            issue_access(random_address(0, drrip_pkg::SET_COUNT - 1, 6));
        end
        drain_lookups();

        for (int i = 0; i < 150; i++)
            issue_access(random_address(2 * drrip_pkg::LEADER_SETS,
                                        drrip_pkg::SET_COUNT - 1, 5));

        // push the policy counter up to its ceiling
        extra = 0;
        while (extra < SAT_EXTRA)
        begin
            if ($urandom_range(0, 7) == 0)
                issue_access(random_address(2 * drrip_pkg::LEADER_SETS,
                                            drrip_pkg::SET_COUNT - 1, 6));
            else
                issue_access(random_address(drrip_pkg::LEADER_SETS,
                                            2 * drrip_pkg::LEADER_SETS - 1, 0));
            if (psel_count == drrip_pkg::PSEL_TOP)
                extra++;
        end
        drain_lookups();

        quiet = 1'b1;
        for (int i = 0; i < 200; i++)
            issue_access(random_address(0, drrip_pkg::SET_COUNT - 1, 6));
        drain_lookups();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d requests: %0d hits, %0d evictions, %0d fills of empty ways.",
                 request_count, hit_count, evict_count,
                 request_count - hit_count - evict_count);
        $display("Policy counter ceiling reached %0d, long hold-off %0d.",
                 psel_top_seen, long_hold_done);
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
